// ===== rtl/core/gle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gle_pkg;

  localparam int unsigned CW_BITS    = 4;
  localparam int unsigned ACC_BITS   = 19;
  localparam int unsigned FIFO_DEPTH = 16;
  localparam logic [3:0]  MIN_BITS_LO = 4'd2;
  localparam logic [3:0]  MIN_BITS_HI = 4'd8;
  localparam logic [3:0]  MIN_BITS_RST = 4'd8;
  localparam logic [2:0]  MAX_RELEASE = 3'd4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_PUT,
    S_LAST_TOK,
    S_END,
    S_PAD,
    S_RELEASE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/gif_lzw_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | payload | handshake
// in       | in_t    | in_valid / in_stall
// out      | out_t   | out_valid / out_stall
// config   | 4 bits  | code_size_we
//
// one pixel per transfer: it is taken, then started; each dictionary entry
// checked takes a ram read and a compare, and a miss ends with a further read;
// each code sent is queued as its full bytes while its leftover bits are kept;
// a frame's first pixel skips the scan; the last pixel also sends the last code
// and the end code, then pads; then the release is sized and up to 4 bytes go
// out, one per unstalled cycle; rst is synchronous; the dictionary needs no
// clearing, only entries below next_free_code are ever compared
module gif_lzw_encoder
  import gle_pkg::*;
#(
  parameter int unsigned DICT_SIZE     = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       code_size_we,
  input  wire logic [3:0] code_size,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data
);

  localparam int unsigned AW = $clog2(DICT_SIZE);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned EW = AW + 8;
  localparam int unsigned FW = $clog2(FIFO_DEPTH);

  state_t state, state_next, ret_state;

  logic [3:0]   min_bits;
  logic [3:0]   frame_bits;
  logic         in_frame;
  logic [7:0]   pix;
  logic         last;
  logic [AW-1:0] prefix;
  logic [NW-1:0] nfc;
  logic [CW_BITS-1:0] cw;
  logic [NW-1:0] c;
  logic [6:0]   bit_buf;
  logic [2:0]   bit_cnt;
  logic [ACC_BITS-1:0] acc;
  logic [4:0]   acc_n;

  logic [7:0]   q_byte [FIFO_DEPTH];
  logic         q_done [FIFO_DEPTH];
  logic [FW-1:0] wptr, rptr;
  logic [FW:0]  q_cnt;
  logic [2:0]   rel;

  logic [EW-1:0] rd_entry;

  // per frame values
  logic [3:0]  fb_new;
  logic [11:0] clear_new, clear_cur;
  logic [7:0]  mask_new, mask_cur, p_cur;
  logic        found, scan_more, match;

  always_comb begin
    fb_new = min_bits;
    if (min_bits < MIN_BITS_LO) fb_new = MIN_BITS_LO;
    if (min_bits > MIN_BITS_HI) fb_new = MIN_BITS_HI;
  end

  assign clear_new = 12'd1 << fb_new;
  assign clear_cur = 12'd1 << frame_bits;
  assign mask_new  = 8'(clear_new - 12'd1);
  assign mask_cur  = 8'(clear_cur - 12'd1);
  assign p_cur     = pix & mask_cur;
  assign scan_more = c < nfc;
  assign match     = rd_entry == {prefix, p_cur};
  assign found     = match;

  // code put and token bookkeeping
  logic        put_load;
  logic [11:0] put_code;
  logic [CW_BITS-1:0] put_w;
  logic        tok, tok_add;
  logic [NW-1:0] nfc_tok;
  logic [13:0] pow_cw;
  logic [CW_BITS-1:0] cw_tok;
  logic        ram_we;

  always_comb begin
    put_load = 1'b0;
    put_code = 12'(prefix);
    put_w    = cw;
    tok      = 1'b0;
    tok_add  = 1'b0;
    case (state)
      S_START: begin
        if (!in_frame) begin
          put_load = 1'b1;
          put_code = clear_new;
          put_w    = CW_BITS'(fb_new + 4'd1);
        end
      end
      S_RD: begin
        if (!scan_more) begin
          put_load = 1'b1;
          tok      = 1'b1;
          tok_add  = 1'b1;
        end
      end
      S_LAST_TOK: begin
        put_load = 1'b1;
        tok      = 1'b1;
      end
      S_END: begin
        put_load = 1'b1;
        put_code = clear_cur + 12'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    nfc_tok = (nfc < NW'(DICT_SIZE)) ? nfc + NW'(1) : nfc;
    pow_cw  = 14'd1 << cw;
    cw_tok  = cw;
    if ((14'(nfc_tok) > pow_cw) && (cw < CW_BITS'(MAX_CODE_BITS))) begin
      cw_tok = cw + CW_BITS'(1);
    end
  end

  assign ram_we = tok_add && (nfc < NW'(DICT_SIZE));

  gle_ram #(
    .WIDTH(EW),
    .DEPTH(DICT_SIZE)
  ) u_dict (
    .clk  (clk),
    .we   (ram_we),
    .waddr(nfc[AW-1:0]),
    .wdata({prefix, p_cur}),
    .raddr(c[AW-1:0]),
    .rdata(rd_entry)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_START;
      S_START:    state_next = in_frame ? S_RD : S_PUT;
      S_RD:       state_next = scan_more ? S_CMP : S_PUT;
      S_CMP: begin
        if (found) state_next = last ? S_LAST_TOK : S_RELEASE;
        else state_next = S_RD;
      end
      S_PUT:      if (acc_n < 5'd8) state_next = ret_state;
      S_LAST_TOK: state_next = S_PUT;
      S_END:      state_next = S_PUT;
      S_PAD:      state_next = S_RELEASE;
      S_RELEASE:  state_next = (q_cnt == '0) ? S_IDLE : S_OUT;
      S_OUT:      if (!out_stall && rel == 3'd1) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall            = state != S_IDLE;
    out_valid           = state == S_OUT;
    out_data.out_byte   = q_byte[rptr];
    out_data.frame_done = q_done[rptr];
    out_data.run_last   = rel == 3'd1;
  end

  logic push, pop;
  assign push = (state == S_PUT && acc_n >= 5'd8) || (state == S_PAD && bit_cnt != 3'd0);
  assign pop  = state == S_OUT && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_RELEASE;
      min_bits   <= MIN_BITS_RST;
      frame_bits <= MIN_BITS_RST;
      in_frame   <= 1'b0;
      prefix     <= '0;
      nfc        <= NW'(258);
      cw         <= CW_BITS'(9);
      bit_buf    <= '0;
      bit_cnt    <= '0;
      wptr       <= '0;
      rptr       <= '0;
      q_cnt      <= '0;
      rel        <= '0;
    end else begin
      state <= state_next;
      if (code_size_we) min_bits <= code_size;
      if (in_valid && !in_stall) begin
        pix  <= in_data.pixel;
        last <= in_data.frame_last;
      end
      if (put_load) begin
        acc   <= ACC_BITS'(bit_buf) | (ACC_BITS'(put_code) << bit_cnt);
        acc_n <= 5'(bit_cnt) + 5'(put_w);
      end
      if (tok) begin
        nfc <= nfc_tok;
        cw  <= cw_tok;
      end
      case (state)
        S_START: begin
          if (!in_frame) begin
            frame_bits <= fb_new;
            nfc        <= NW'(clear_new) + NW'(2);
            cw         <= CW_BITS'(fb_new + 4'd1);
            prefix     <= AW'(pix & mask_new);
            in_frame   <= 1'b1;
            ret_state  <= last ? S_LAST_TOK : S_RELEASE;
          end else begin
            c <= NW'(clear_cur) + NW'(2);
          end
        end
        S_RD: begin
          if (!scan_more) begin
            prefix    <= AW'(p_cur);
            ret_state <= last ? S_LAST_TOK : S_RELEASE;
          end
        end
        S_CMP: begin
          if (found) prefix <= c[AW-1:0];
          else c <= c + NW'(1);
        end
        S_LAST_TOK: ret_state <= S_END;
        S_END:      ret_state <= S_PAD;
        S_PUT: begin
          if (acc_n >= 5'd8) begin
            q_byte[wptr] <= acc[7:0];
            q_done[wptr] <= 1'b0;
            acc          <= acc >> 8;
            acc_n        <= acc_n - 5'd8;
          end else begin
            bit_buf <= acc[6:0];
            bit_cnt <= acc_n[2:0];
          end
        end
        S_PAD: begin
          // padded byte closes the frame, else the last full byte does
          if (bit_cnt != 3'd0) begin
            q_byte[wptr] <= {1'b0, bit_buf};
            q_done[wptr] <= 1'b1;
          end else begin
            q_done[wptr - FW'(1)] <= 1'b1;
          end
          bit_buf  <= '0;
          bit_cnt  <= '0;
          in_frame <= 1'b0;
        end
        S_RELEASE: rel <= (q_cnt > (FW+1)'(MAX_RELEASE)) ? MAX_RELEASE : 3'(q_cnt);
        S_OUT:     if (pop) rel <= rel - 3'd1;
        default: begin
        end
      endcase
      if (push) wptr <= wptr + FW'(1);
      if (pop)  rptr <= rptr + FW'(1);
      if (push && !pop) q_cnt <= q_cnt + (FW+1)'(1);
      else if (pop && !push) q_cnt <= q_cnt - (FW+1)'(1);
    end
  end

  a_out_has_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> q_cnt != '0)
    else $error("output transfer with empty byte queue");

  a_cw_cap: assert property (@(posedge clk) disable iff (rst)
    cw <= CW_BITS'(MAX_CODE_BITS))
    else $error("code width above cap");

  a_nfc_cap: assert property (@(posedge clk) disable iff (rst)
    nfc <= NW'(DICT_SIZE))
    else $error("next free code beyond dictionary");

endmodule
`default_nettype wire

// ===== rtl/core/gle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gle_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
